// ===== hdl/opamp_distortion_biquad_assert.svh =====
// Assertion macros for the verification of the biquad block.
// Depends on nothing; included by the checker module.
`ifndef OPAMP_DISTORTION_BIQUAD_ASSERT_SVH
`define OPAMP_DISTORTION_BIQUAD_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ODB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ODB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold later than the antecedent.
`define ODB_ASSERT_LATER2(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// ===== hdl/odb_pkg.sv =====
// Package of the op-amp distortion biquad: coefficient format, register
// indexes and the coefficient set type. Depends on nothing.
package odb_pkg;

  localparam int COEF_W     = 24;
  localparam int COEF_FRAC  = 20;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_set_t;

  localparam logic signed [COEF_W-1:0] B0_RESET = COEF_W'(1 << COEF_FRAC);

endpackage

// ===== hdl/opamp_distortion_biquad.sv =====
// Top level of the op-amp distortion biquad: stream ports, coefficient
// registers, per-channel history and the two pipeline registers.
// Depends on odb_pkg and odb_biquad_core.
//
// Usage: one input transaction carries one signed sample in s_axis_tdata and
// its channel in s_axis_tuser. Each input yields exactly one result
// transaction on the m_axis side with the filtered, saturated sample in
// m_axis_tdata, and the channel and clip flag in m_axis_tuser.
// An accepted input goes into the input register and its result into the
// result register, from which it is offered, once the output can advance.
// Throughput is one transaction per cycle, also on one channel back to back,
// while m_axis_tready is not held low: the filter equation is combinational
// between the registers, and history updates as the result register loads.
// Coefficients are written on the cfg channel, which is always ready; writes
// are meant to happen while no transaction is in flight.
// When the receiver holds m_axis_tready low, the result stays on the output,
// one more input is taken into the input register, and then s_axis_tready
// drops until the result is taken.
// Reset clears all history to zero, sets b0 to 1.0 and the other
// coefficients to zero, and empties both pipeline registers.
module opamp_distortion_biquad #(
  parameter int NUM_CHANNELS = 2,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Bits from the lowest: sample_in, zero padding.
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // Bits from the lowest: chan.
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Bits from the lowest: sample_out, zero padding.
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,
  // Bits from the lowest: chan_out, clipped.
  output logic [1:0]                          m_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [odb_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [odb_pkg::COEF_W-1:0]          cfg_data_i
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  odb_pkg::coef_set_t coef_q;

  logic signed [SAMPLE_BITS-1:0] x1_q [NUM_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] x2_q [NUM_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y1_q [NUM_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y2_q [NUM_CHANNELS];

  logic                          in_valid_q;
  logic                          in_chan_q;
  logic signed [SAMPLE_BITS-1:0] in_x_q;

  logic                          out_valid_q;
  logic                          out_chan_q;
  logic                          out_clip_q;
  logic signed [SAMPLE_BITS-1:0] out_y_q;

  logic                          advance;
  logic                          fire;
  logic                          in_take;
  logic [CH_W-1:0]               ch_idx;
  logic signed [SAMPLE_BITS-1:0] y_d;
  logic                          clip_d;

  assign cfg_ready_o   = 1'b1;
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign ch_idx        = (NUM_CHANNELS > 1) ? CH_W'(in_chan_q) : '0;

  odb_biquad_core #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_core (
    .coef_i (coef_q),
    .x_i    (in_x_q),
    .x1_i   (x1_q[ch_idx]),
    .x2_i   (x2_q[ch_idx]),
    .y1_i   (y1_q[ch_idx]),
    .y2_i   (y2_q[ch_idx]),
    .y_o    (y_d),
    .clip_o (clip_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= odb_pkg::B0_RESET;
      coef_q.b1 <= '0;
      coef_q.b2 <= '0;
      coef_q.a1 <= '0;
      coef_q.a2 <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        odb_pkg::REG_B0: coef_q.b0 <= cfg_data_i;
        odb_pkg::REG_B1: coef_q.b1 <= cfg_data_i;
        odb_pkg::REG_B2: coef_q.b2 <= cfg_data_i;
        odb_pkg::REG_A1: coef_q.a1 <= cfg_data_i;
        odb_pkg::REG_A2: coef_q.a2 <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_chan_q <= s_axis_tuser;
      in_x_q    <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
    if (fire) begin
      out_chan_q <= in_chan_q;
      out_clip_q <= clip_d;
      out_y_q    <= y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        x1_q[c] <= '0;
        x2_q[c] <= '0;
        y1_q[c] <= '0;
        y2_q[c] <= '0;
      end
    end else if (fire) begin
      x2_q[ch_idx] <= x1_q[ch_idx];
      x1_q[ch_idx] <= in_x_q;
      y2_q[ch_idx] <= y1_q[ch_idx];
      y1_q[ch_idx] <= y_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(unsigned'(out_y_q));
  assign m_axis_tuser  = {out_clip_q, out_chan_q};

endmodule

// ===== hdl/odb_biquad_core.sv =====
// Combinational biquad datapath: five products, exact sum, rounding and
// saturation to the sample format. Depends on odb_pkg.
module odb_biquad_core #(
  parameter int SAMPLE_BITS = 24
) (
  input  odb_pkg::coef_set_t             coef_i,
  input  logic signed [SAMPLE_BITS-1:0]  x_i,
  input  logic signed [SAMPLE_BITS-1:0]  x1_i,
  input  logic signed [SAMPLE_BITS-1:0]  x2_i,
  input  logic signed [SAMPLE_BITS-1:0]  y1_i,
  input  logic signed [SAMPLE_BITS-1:0]  y2_i,
  output logic signed [SAMPLE_BITS-1:0]  y_o,
  output logic                           clip_o
);

  localparam int PROD_W = SAMPLE_BITS + odb_pkg::COEF_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int RND_W  = ACC_W - odb_pkg::COEF_FRAC;

  localparam logic signed [RND_W-1:0] MAXV =
    RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] MINV =
    RND_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
  localparam logic signed [ACC_W-1:0] HALF_LSB =
    ACC_W'(64'sd1 <<< (odb_pkg::COEF_FRAC - 1));

  logic signed [PROD_W-1:0] m0, m1, m2, m3, m4;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [RND_W-1:0]  y_rnd;

  assign m0 = coef_i.b0 * x_i;
  assign m1 = coef_i.b1 * x1_i;
  assign m2 = coef_i.b2 * x2_i;
  assign m3 = coef_i.a1 * y1_i;
  assign m4 = coef_i.a2 * y2_i;

  assign acc = ACC_W'(m0) + ACC_W'(m1) + ACC_W'(m2) - ACC_W'(m3) - ACC_W'(m4);

  // Round half up, then drop the coefficient fraction bits.
  assign acc_rnd = acc + HALF_LSB;
  assign y_rnd   = acc_rnd[ACC_W-1:odb_pkg::COEF_FRAC];

  always_comb begin
    if (y_rnd > MAXV) begin
      y_o    = MAXV[SAMPLE_BITS-1:0];
      clip_o = 1'b1;
    end else if (y_rnd < MINV) begin
      y_o    = MINV[SAMPLE_BITS-1:0];
      clip_o = 1'b1;
    end else begin
      y_o    = y_rnd[SAMPLE_BITS-1:0];
      clip_o = 1'b0;
    end
  end

endmodule

// ===== hdl/odb_checker.sv =====
// Port-level checker of the op-amp distortion biquad and its bind statement.
// Depends on opamp_distortion_biquad_assert.svh.
`include "opamp_distortion_biquad_assert.svh"

module odb_checker #(
  parameter int SAMPLE_BITS  = 24
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  input logic [1:0]                       m_axis_tuser
);

  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic in_xfer;
  logic out_clip;
  logic [SAMPLE_BITS-1:0] out_sample;

  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_clip   = m_axis_tuser[1];
  assign out_sample = m_axis_tdata[SAMPLE_BITS-1:0];

  `ODB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "Stalled result changed or was dropped.")

  `ODB_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid,
    s_axis_tready, "Input was refused while no result was pending.")

  `ODB_ASSERT_LATER2(a_result_follows, clk_i, rst_ni, in_xfer,
    m_axis_tvalid, "No result offered two cycles after an input transaction.")

  `ODB_ASSERT_NOW(a_clip_at_rail, clk_i, rst_ni, m_axis_tvalid && out_clip,
    (out_sample == SAT_MAX) || (out_sample == SAT_MIN),
    "Clip flag set on a sample that is not at a saturation rail.")

endmodule

bind opamp_distortion_biquad odb_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_odb_checker (.*);
